// ===== hw/rtl/event_feedback_pattern_sequencer_top_defines.svh =====
// ---------------------------------------------------------------------------
// Event feedback pattern sequencer assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef EVENT_FEEDBACK_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define EVENT_FEEDBACK_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define EFPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("efps assertion failed");

// next-cycle implication
`define EFPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("efps assertion failed");

`endif

// ===== hw/rtl/efps_pkg.sv =====
// ---------------------------------------------------------------------------
// efps_pkg
// Types, codes and pattern tables of the event feedback pattern sequencer.
// ---------------------------------------------------------------------------
package efps_pkg;

   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_EVENT   = 2'd1;
   localparam logic [1:0] FUNC_BATTERY = 2'd2;

   localparam logic [2:0] EV_SHUTTER      = 3'd0;
   localparam logic [2:0] EV_COUNTDOWN    = 3'd1;
   localparam logic [2:0] EV_CONNECTED    = 3'd2;
   localparam logic [2:0] EV_DISCONNECTED = 3'd3;
   localparam logic [2:0] EV_LOW_BATTERY  = 3'd4;

   localparam logic [2:0] MODE_OFF       = 3'd0;
   localparam logic [2:0] MODE_SOUND     = 3'd1;
   localparam logic [2:0] MODE_LIGHT     = 3'd2;
   localparam logic [2:0] MODE_VIBRATE   = 3'd3;
   localparam logic [2:0] MODE_SND_LIGHT = 3'd4;

   localparam logic [2:0] REG_OUTPUT_MODE  = 3'd0;
   localparam logic [2:0] REG_EVENT_ENABLE = 3'd1;
   localparam logic [2:0] REG_VOLUME       = 3'd2;
   localparam logic [2:0] REG_CAPABILITIES = 3'd3;
   localparam logic [2:0] REG_LED_INVERT   = 3'd4;

   localparam logic [6:0] BATTERY_LOW_PERCENT = 7'd10;
   localparam logic [2:0] BATTERY_LOW_SAMPLES = 3'd6;
   localparam logic [7:0] VIB_DRIVE           = 8'd255;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  event_code;
      logic [31:0] now_ms;
      logic        speaker_busy;
      logic [6:0]  battery_level;
      logic        charging;
   } item_type;

   typedef struct packed {
      logic        tone_start;
      logic [11:0] tone_freq;
      logic [7:0]  tone_ms;
      logic        speaker_power;
      logic        led_pin_level;
      logic [7:0]  motor_drive;
      logic        timer_running;
   } result_type;

   typedef struct packed {
      logic [2:0] output_mode;
      logic [3:0] event_enable;
      logic [7:0] volume;
      logic [2:0] capabilities;
      logic       led_invert;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  pattern_event;
      logic        tone_index;
      logic [1:0]  tone_count;
      logic        tone_playing;
      logic        tone_in_gap;
      logic [31:0] tone_deadline;
      logic        speaker_active;
      logic [1:0]  light_index;
      logic [1:0]  light_count;
      logic        light_lit;
      logic [31:0] light_deadline;
      logic [8:0]  light_on_time;
      logic [8:0]  light_off_time;
      logic        vib_index;
      logic [1:0]  vib_count;
      logic        vib_active;
      logic [31:0] vib_deadline;
      logic        tick_enabled;
      logic [2:0]  low_sample_count;
      logic        low_warned;
   } state_type;

   // wrap-safe: due once now - deadline is not negative
   function automatic logic due(input logic [31:0] now, input logic [31:0] deadline);
      logic [31:0] diff;
      diff = now - deadline;
      return !diff[31];
   endfunction

   function automatic logic [11:0] tone_hz(input logic [2:0] ev, input logic ix);
      logic [11:0] hz;
      case (ev)
         EV_SHUTTER:      hz = ix ? 12'd0    : 12'd4000;
         EV_COUNTDOWN:    hz = ix ? 12'd0    : 12'd2000;
         EV_CONNECTED:    hz = ix ? 12'd3000 : 12'd2000;
         EV_DISCONNECTED: hz = ix ? 12'd2000 : 12'd3000;
         EV_LOW_BATTERY:  hz = 12'd1000;
         default:         hz = 12'd0;
      endcase
      return hz;
   endfunction

   function automatic logic [7:0] tone_len(input logic [2:0] ev, input logic ix);
      logic [7:0] len;
      case (ev)
         EV_SHUTTER, EV_COUNTDOWN:       len = ix ? 8'd0 : 8'd40;
         EV_CONNECTED, EV_DISCONNECTED:  len = 8'd60;
         EV_LOW_BATTERY:                 len = 8'd200;
         default:                        len = 8'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] tone_gap(input logic [2:0] ev, input logic ix);
      logic [7:0] gap;
      case (ev)
         EV_CONNECTED, EV_DISCONNECTED: gap = ix ? 8'd0 : 8'd20;
         EV_LOW_BATTERY:                gap = ix ? 8'd0 : 8'd100;
         default:                       gap = 8'd0;
      endcase
      return gap;
   endfunction

   function automatic logic [1:0] tone_num(input logic [2:0] ev);
      logic [1:0] n;
      case (ev)
         EV_SHUTTER, EV_COUNTDOWN:                      n = 2'd1;
         EV_CONNECTED, EV_DISCONNECTED, EV_LOW_BATTERY: n = 2'd2;
         default:                                       n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [8:0] led_on(input logic [2:0] ev);
      logic [8:0] t;
      case (ev)
         EV_SHUTTER, EV_COUNTDOWN:      t = 9'd40;
         EV_CONNECTED, EV_DISCONNECTED: t = 9'd60;
         EV_LOW_BATTERY:                t = 9'd100;
         default:                       t = 9'd0;
      endcase
      return t;
   endfunction

   function automatic logic [8:0] led_off(input logic [2:0] ev);
      logic [8:0] t;
      case (ev)
         EV_CONNECTED:    t = 9'd80;
         EV_DISCONNECTED: t = 9'd100;
         EV_LOW_BATTERY:  t = 9'd300;
         default:         t = 9'd0;
      endcase
      return t;
   endfunction

   function automatic logic [1:0] led_num(input logic [2:0] ev);
      logic [1:0] n;
      case (ev)
         EV_SHUTTER, EV_COUNTDOWN:          n = 2'd1;
         EV_CONNECTED:                      n = 2'd2;
         EV_DISCONNECTED, EV_LOW_BATTERY:   n = 2'd3;
         default:                           n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] vib_len(input logic [2:0] ev, input logic ix);
      logic [7:0] len;
      case (ev)
         EV_SHUTTER:      len = ix ? 8'd0 : 8'd60;
         EV_CONNECTED:    len = ix ? 8'd0 : 8'd100;
         EV_DISCONNECTED: len = 8'd100;
         EV_LOW_BATTERY:  len = 8'd150;
         default:         len = 8'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] vib_gap(input logic [2:0] ev, input logic ix);
      logic [7:0] gap;
      case (ev)
         EV_DISCONNECTED: gap = ix ? 8'd0 : 8'd100;
         EV_LOW_BATTERY:  gap = ix ? 8'd0 : 8'd150;
         default:         gap = 8'd0;
      endcase
      return gap;
   endfunction

   function automatic logic [1:0] vib_num(input logic [2:0] ev);
      logic [1:0] n;
      case (ev)
         EV_SHUTTER, EV_CONNECTED:          n = 2'd1;
         EV_DISCONNECTED, EV_LOW_BATTERY:   n = 2'd2;
         default:                           n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/efps_engine.sv =====
// ---------------------------------------------------------------------------
// efps_engine
// Sequencer state and its single-pass update for one item per cycle while advance is high.
// ---------------------------------------------------------------------------
module efps_engine import efps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_type   st;
      logic        o_start;
      logic [11:0] o_freq;
      logic [7:0]  o_ms;
      logic        sig_fire;
      logic [2:0]  sig_ev;
      logic [3:0]  mask;
      logic        tick_run;
      logic        begin_tone;
      logic        snd;
      logic        lgt;
      logic        vib;
      logic        supported;
      logic [7:0]  g;
      logic [2:0]  ev;

      st         = state_ff;
      o_start    = 1'b0;
      o_freq     = '0;
      o_ms       = '0;
      sig_fire   = 1'b0;
      sig_ev     = item.event_code;
      tick_run   = 1'b0;
      begin_tone = 1'b0;
      g          = '0;

      snd = (cfg.output_mode == MODE_SOUND) || (cfg.output_mode == MODE_SND_LIGHT);
      lgt = (cfg.output_mode == MODE_LIGHT) || (cfg.output_mode == MODE_SND_LIGHT);
      vib = (cfg.output_mode == MODE_VIBRATE);
      supported = (cfg.output_mode <= MODE_SND_LIGHT)
                  && !(snd && !cfg.capabilities[0])
                  && !(lgt && !cfg.capabilities[1])
                  && !(vib && !cfg.capabilities[2]);

      case (item.func)
         FUNC_TICK:  tick_run = state_ff.tick_enabled;
         FUNC_EVENT: sig_fire = 1'b1;
         FUNC_BATTERY: begin
            if (item.charging) begin
               st.low_sample_count = '0;
               st.low_warned       = 1'b0;
            end else if (item.battery_level > BATTERY_LOW_PERCENT) begin
               st.low_sample_count = '0;
            end else begin
               if (st.low_sample_count < BATTERY_LOW_SAMPLES)
                  st.low_sample_count = st.low_sample_count + 3'd1;
               if (st.low_sample_count >= BATTERY_LOW_SAMPLES && !st.low_warned) begin
                  st.low_warned = 1'b1;
                  sig_fire      = 1'b1;
                  sig_ev        = EV_LOW_BATTERY;
               end
            end
         end
         default: ;
      endcase

      unique case (sig_ev)
         EV_SHUTTER:                    mask = 4'b0001;
         EV_COUNTDOWN:                  mask = 4'b0010;
         EV_CONNECTED, EV_DISCONNECTED: mask = 4'b0100;
         EV_LOW_BATTERY:                mask = 4'b1000;
         default:                       mask = 4'b0000;
      endcase

      // event: load the pattern into the selected channels
      if (sig_fire && cfg.output_mode != MODE_OFF && supported
          && (cfg.event_enable & mask) != 4'd0) begin
         st.speaker_active = 1'b0;
         st.tone_playing   = 1'b0;
         st.tone_in_gap    = 1'b0;
         st.tone_count     = '0;
         st.light_count    = '0;
         st.vib_count      = '0;
         st.pattern_event  = sig_ev;
         if (snd) begin
            st.tone_count = tone_num(sig_ev);
            st.tone_index = 1'b0;
            begin_tone    = 1'b1;
         end
         if (lgt && cfg.capabilities[1] && led_num(sig_ev) != 2'd0) begin
            st.light_on_time  = led_on(sig_ev);
            st.light_off_time = led_off(sig_ev);
            st.light_count    = led_num(sig_ev);
            st.light_index    = '0;
            st.light_lit      = 1'b1;
            st.light_deadline = item.now_ms + 32'(led_on(sig_ev));
         end
         if (vib && cfg.capabilities[2] && vib_num(sig_ev) != 2'd0) begin
            st.vib_count    = vib_num(sig_ev);
            st.vib_index    = 1'b0;
            st.vib_active   = 1'b1;
            st.vib_deadline = item.now_ms + 32'(vib_len(sig_ev, 1'b0));
         end
         st.tick_enabled = 1'b1;
      end

      ev = st.pattern_event;

      // tick: tone channel
      if (tick_run && st.tone_count != 2'd0) begin
         if (st.tone_playing) begin
            if (due(item.now_ms, st.tone_deadline) && !item.speaker_busy) begin
               st.speaker_active = 1'b0;
               st.tone_playing   = 1'b0;
               st.tone_in_gap    = 1'b0;
               if (({1'b0, st.tone_index} + 2'd1) < st.tone_count) begin
                  g = tone_gap(ev, st.tone_index);
                  st.tone_in_gap = (g != 8'd0);
                  if (st.tone_in_gap) begin
                     st.tone_deadline = item.now_ms + 32'(g);
                  end else begin
                     st.tone_index = ~st.tone_index;
                     begin_tone    = 1'b1;
                  end
               end else begin
                  st.tone_count = '0;
               end
            end
         end else if (st.tone_in_gap && due(item.now_ms, st.tone_deadline)) begin
            st.tone_in_gap = 1'b0;
            st.tone_index  = ~st.tone_index;
            begin_tone     = 1'b1;
         end
      end

      if (begin_tone) begin
         if ({1'b0, st.tone_index} >= st.tone_count) begin
            st.tone_count = '0;
         end else begin
            o_start           = 1'b1;
            o_freq            = tone_hz(ev, st.tone_index);
            o_ms              = tone_len(ev, st.tone_index);
            st.speaker_active = 1'b1;
            st.tone_playing   = 1'b1;
            st.tone_deadline  = item.now_ms + 32'(tone_len(ev, st.tone_index));
         end
      end

      // tick: light channel
      if (tick_run && st.light_count != 2'd0 && due(item.now_ms, st.light_deadline)) begin
         if (st.light_lit) begin
            st.light_lit = 1'b0;
            if (({1'b0, st.light_index} + 3'd1) >= {1'b0, st.light_count})
               st.light_count = '0;
            else
               st.light_deadline = item.now_ms + 32'(st.light_off_time);
         end else begin
            st.light_index    = st.light_index + 2'd1;
            st.light_lit      = 1'b1;
            st.light_deadline = item.now_ms + 32'(st.light_on_time);
         end
      end

      // tick: vibration channel
      if (tick_run && st.vib_count != 2'd0 && due(item.now_ms, st.vib_deadline)) begin
         if (st.vib_active) begin
            st.vib_active = 1'b0;
            if (({1'b0, st.vib_index} + 2'd1) >= st.vib_count)
               st.vib_count = '0;
            else
               st.vib_deadline = item.now_ms + 32'(vib_gap(ev, st.vib_index));
         end else begin
            st.vib_index    = ~st.vib_index;
            st.vib_active   = 1'b1;
            st.vib_deadline = item.now_ms + 32'(vib_len(ev, st.vib_index));
         end
      end

      if (tick_run && st.tone_count == 2'd0 && st.light_count == 2'd0
          && st.vib_count == 2'd0)
         st.tick_enabled = 1'b0;

      state_in = st;

      result.tone_start    = o_start;
      result.tone_freq     = o_freq;
      result.tone_ms       = o_ms;
      result.speaker_power = st.speaker_active;
      result.led_pin_level = cfg.capabilities[1] & (st.light_lit ^ cfg.led_invert);
      result.motor_drive   = st.vib_active ? VIB_DRIVE : 8'd0;
      result.timer_running = st.tick_enabled;
   end

endmodule

// ===== hw/rtl/event_feedback_pattern_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// event_feedback_pattern_sequencer_top
// Tone, LED and vibration pattern sequencer driven by ticks, events and
// battery samples.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  input stream, one transfer per item: tick, event or battery
//          sample with its millisecond timestamp (kind in req_tuser).
//   rsp_*  result stream, exactly one transfer per input item, in order.
//   csr_*  register write channel, always ready; write only while idle.
// Path: an accepted item passes through the input register, then the result
//   register, before rsp_tvalid rises.
// Throughput: one item per cycle unless the result stream stalls; the state
//   update for an item is one combinational pass from the input register into
//   the state and result registers, so the next item sees the updated state.
// Reset: all channels stop, the tick timer is off, registers return to
//   mode off, all events enabled, no capabilities, LED pin inverted.
// Stall: while rsp_tready is low the result holds and one more item is
//   held in the input register; req_tready then drops.
// ---------------------------------------------------------------------------
`include "event_feedback_pattern_sequencer_top_defines.svh"

module event_feedback_pattern_sequencer_top import efps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] event_code, [34:3] now_ms, [35] speaker_busy,
   // [42:36] battery_level, [43] charging, [47:44] zero
   input  logic [47:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tone_start, [12:1] tone_freq, [20:13] tone_ms, [21] speaker_power,
   // [22] led_pin_level, [30:23] motor_drive, [31] timer_running
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result;
   logic       advance;
   logic       req_accept;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_mode  <= MODE_OFF;
         cfg_ff.event_enable <= 4'hF;
         cfg_ff.volume       <= '0;
         cfg_ff.capabilities <= '0;
         cfg_ff.led_invert   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_OUTPUT_MODE:  cfg_ff.output_mode  <= csr_wdata[2:0];
            REG_EVENT_ENABLE: cfg_ff.event_enable <= csr_wdata[3:0];
            REG_VOLUME:       cfg_ff.volume       <= csr_wdata;
            REG_CAPABILITIES: cfg_ff.capabilities <= csr_wdata[2:0];
            REG_LED_INVERT:   cfg_ff.led_invert   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.func          <= req_tuser;
         item_ff.event_code    <= req_tdata[2:0];
         item_ff.now_ms        <= req_tdata[34:3];
         item_ff.speaker_busy  <= req_tdata[35];
         item_ff.battery_level <= req_tdata[42:36];
         item_ff.charging      <= req_tdata[43];
      end
      if (advance)
         rsp_ff <= result;
   end

   efps_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.timer_running, rsp_ff.motor_drive,
                        rsp_ff.led_pin_level, rsp_ff.speaker_power,
                        rsp_ff.tone_ms, rsp_ff.tone_freq, rsp_ff.tone_start};

   `EFPS_ASSERT_IMPL(a_tone_powers_speaker, clock, reset,
      rsp_tvalid && rsp_tdata[0], rsp_tdata[21] && rsp_tdata[31])
   `EFPS_ASSERT_IMPL(a_tone_has_freq, clock, reset,
      rsp_tvalid && rsp_tdata[0], rsp_tdata[12:1] != 12'd0 && rsp_tdata[20:13] != 8'd0)
   `EFPS_ASSERT_NEXT(a_held_item_kept, clock, reset,
      in_valid_ff && !advance, in_valid_ff && rsp_valid_ff)

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Event feedback pattern sequencer testbench
// Drives ticks, events and battery samples into the sequencer through its
// request stream, predicts every result with a cycle-free model of the tone,
// LED and vibration channels, and checks each response transfer in order.
// Register settings change between phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench import efps_pkg::*; ();

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam logic [2:0] EV_UNASSIGNED = 3'd5;
   localparam int SETTLE_CYCLES  = 4;
   localparam int STALL_LIMIT    = 5000;
   localparam int MAX_REPORTS    = 40;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 700;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 124;

   typedef struct packed {
      logic [11:0] hz0;
      logic [11:0] hz1;
      logic [7:0]  len0;
      logic [7:0]  len1;
      logic [7:0]  gap0;
      logic [1:0]  tones;
      logic [8:0]  lit_ms;
      logic [8:0]  dark_ms;
      logic [1:0]  blinks;
      logic [7:0]  vlen0;
      logic [7:0]  vlen1;
      logic [7:0]  vgap0;
      logic [1:0]  pulses;
   } feedback_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   cfg_type    seq_cfg;
   state_type  seq_st;
   logic       tone_fire;
   logic [11:0] tone_hz_out;
   logic [7:0] tone_len_out;

   item_type   pending_items[$];
   result_type predicted_outputs[$];
   item_type   live_item;
   int         in_flight = 0;
   int         mismatch_count = 0;
   int         results_seen = 0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         hold_left = 0;
   bit         long_hold_done = 1'b0;
   int         rx_style = 0;
   int         rx_left = 0;
   int         rx_phase = 0;
   int         quiet_cycles = 0;
   logic [31:0] wall_ms;

   event_feedback_pattern_sequencer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------- prediction ----------------

   function automatic feedback_pattern_type pattern_for(input logic [2:0] ev);
      feedback_pattern_type p;
      p = '0;
      case (ev)
         EV_SHUTTER: begin
            p.hz0 = 12'd4000; p.len0 = 8'd40; p.tones = 2'd1;
            p.lit_ms = 9'd40; p.blinks = 2'd1;
            p.vlen0 = 8'd60; p.pulses = 2'd1;
         end
         EV_COUNTDOWN: begin
            p.hz0 = 12'd2000; p.len0 = 8'd40; p.tones = 2'd1;
            p.lit_ms = 9'd40; p.blinks = 2'd1;
         end
         EV_CONNECTED: begin
            p.hz0 = 12'd2000; p.hz1 = 12'd3000; p.len0 = 8'd60; p.len1 = 8'd60;
            p.gap0 = 8'd20; p.tones = 2'd2;
            p.lit_ms = 9'd60; p.dark_ms = 9'd80; p.blinks = 2'd2;
            p.vlen0 = 8'd100; p.pulses = 2'd1;
         end
         EV_DISCONNECTED: begin
            p.hz0 = 12'd3000; p.hz1 = 12'd2000; p.len0 = 8'd60; p.len1 = 8'd60;
            p.gap0 = 8'd20; p.tones = 2'd2;
            p.lit_ms = 9'd60; p.dark_ms = 9'd100; p.blinks = 2'd3;
            p.vlen0 = 8'd100; p.vlen1 = 8'd100; p.vgap0 = 8'd100; p.pulses = 2'd2;
         end
         EV_LOW_BATTERY: begin
            p.hz0 = 12'd1000; p.hz1 = 12'd1000; p.len0 = 8'd200; p.len1 = 8'd200;
            p.gap0 = 8'd100; p.tones = 2'd2;
            p.lit_ms = 9'd100; p.dark_ms = 9'd300; p.blinks = 2'd3;
            p.vlen0 = 8'd150; p.vlen1 = 8'd150; p.vgap0 = 8'd150; p.pulses = 2'd2;
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic logic deadline_reached(input logic [31:0] now, input logic [31:0] dl);
      logic [31:0] diff;
      diff = now - dl;
      return ~diff[31];
   endfunction

   function automatic logic mode_usable();
      logic snd, lgt, vib;
      snd = seq_cfg.output_mode == MODE_SOUND || seq_cfg.output_mode == MODE_SND_LIGHT;
      lgt = seq_cfg.output_mode == MODE_LIGHT || seq_cfg.output_mode == MODE_SND_LIGHT;
      vib = seq_cfg.output_mode == MODE_VIBRATE;
      if (seq_cfg.output_mode > MODE_SND_LIGHT) return 1'b0;
      if (snd && !seq_cfg.capabilities[0]) return 1'b0;
      if (lgt && !seq_cfg.capabilities[1]) return 1'b0;
      if (vib && !seq_cfg.capabilities[2]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic silence_speaker();
      seq_st.speaker_active = 1'b0;
      seq_st.tone_playing = 1'b0;
      seq_st.tone_in_gap = 1'b0;
   endtask

   task automatic start_tone(input logic [31:0] now);
      feedback_pattern_type p;
      logic [7:0] len;
      p = pattern_for(seq_st.pattern_event);
      if (seq_st.tone_index >= seq_st.tone_count) begin
         seq_st.tone_count = 2'd0;
      end else begin
         len = seq_st.tone_index ? p.len1 : p.len0;
         tone_fire = 1'b1;
         tone_hz_out = seq_st.tone_index ? p.hz1 : p.hz0;
         tone_len_out = len;
         seq_st.speaker_active = 1'b1;
         seq_st.tone_playing = 1'b1;
         seq_st.tone_deadline = now + len;
      end
   endtask

   task automatic load_pattern(input logic [2:0] ev, input logic [31:0] now);
      feedback_pattern_type p;
      logic [3:0] mask;
      logic snd, lgt, vib;
      case (ev)
         EV_SHUTTER:                    mask = 4'b0001;
         EV_COUNTDOWN:                  mask = 4'b0010;
         EV_CONNECTED, EV_DISCONNECTED: mask = 4'b0100;
         EV_LOW_BATTERY:                mask = 4'b1000;
         default:                       mask = 4'b0000;
      endcase
      if (seq_cfg.output_mode != MODE_OFF && mode_usable() &&
          (seq_cfg.event_enable & mask) != 4'd0) begin
         snd = seq_cfg.output_mode == MODE_SOUND || seq_cfg.output_mode == MODE_SND_LIGHT;
         lgt = seq_cfg.output_mode == MODE_LIGHT || seq_cfg.output_mode == MODE_SND_LIGHT;
         vib = seq_cfg.output_mode == MODE_VIBRATE;
         p = pattern_for(ev);
         silence_speaker();
         seq_st.tone_count = 2'd0;
         seq_st.light_count = 2'd0;
         seq_st.vib_count = 2'd0;
         seq_st.pattern_event = ev;
         if (snd) begin
            seq_st.tone_count = p.tones;
            seq_st.tone_index = 1'b0;
            start_tone(now);
         end
         if (lgt && seq_cfg.capabilities[1] && p.blinks != 2'd0) begin
            seq_st.light_on_time = p.lit_ms;
            seq_st.light_off_time = p.dark_ms;
            seq_st.light_count = p.blinks;
            seq_st.light_index = 2'd0;
            seq_st.light_lit = 1'b1;
            seq_st.light_deadline = now + p.lit_ms;
         end
         if (vib && seq_cfg.capabilities[2] && p.pulses != 2'd0) begin
            seq_st.vib_count = p.pulses;
            seq_st.vib_index = 1'b0;
            seq_st.vib_active = 1'b1;
            seq_st.vib_deadline = now + p.vlen0;
         end
         seq_st.tick_enabled = 1'b1;
      end
   endtask

   task automatic advance_channels(input logic [31:0] now, input logic busy);
      feedback_pattern_type p;
      logic [7:0] g;
      p = pattern_for(seq_st.pattern_event);
      if (seq_st.tone_count > 2'd0) begin
         if (seq_st.tone_playing) begin
            if (deadline_reached(now, seq_st.tone_deadline) && !busy) begin
               silence_speaker();
               if (seq_st.tone_index + 1 < seq_st.tone_count) begin
                  g = seq_st.tone_index ? 8'd0 : p.gap0;
                  seq_st.tone_in_gap = g > 8'd0;
                  if (seq_st.tone_in_gap) begin
                     seq_st.tone_deadline = now + g;
                  end else begin
                     seq_st.tone_index = seq_st.tone_index + 1'b1;
                     start_tone(now);
                  end
               end else begin
                  seq_st.tone_count = 2'd0;
               end
            end
         end else if (seq_st.tone_in_gap && deadline_reached(now, seq_st.tone_deadline)) begin
            seq_st.tone_in_gap = 1'b0;
            seq_st.tone_index = seq_st.tone_index + 1'b1;
            start_tone(now);
         end
      end
      if (seq_st.light_count > 2'd0 && deadline_reached(now, seq_st.light_deadline)) begin
         if (seq_st.light_lit) begin
            seq_st.light_lit = 1'b0;
            if (seq_st.light_index + 1 >= seq_st.light_count) seq_st.light_count = 2'd0;
            else seq_st.light_deadline = now + seq_st.light_off_time;
         end else begin
            seq_st.light_index = seq_st.light_index + 2'd1;
            seq_st.light_lit = 1'b1;
            seq_st.light_deadline = now + seq_st.light_on_time;
         end
      end
      if (seq_st.vib_count > 2'd0 && deadline_reached(now, seq_st.vib_deadline)) begin
         if (seq_st.vib_active) begin
            seq_st.vib_active = 1'b0;
            if (seq_st.vib_index + 1 >= seq_st.vib_count) seq_st.vib_count = 2'd0;
            else seq_st.vib_deadline = now + (seq_st.vib_index ? 8'd0 : p.vgap0);
         end else begin
            seq_st.vib_index = seq_st.vib_index + 1'b1;
            seq_st.vib_active = 1'b1;
            seq_st.vib_deadline = now + (seq_st.vib_index ? p.vlen1 : p.vlen0);
         end
      end
      if (seq_st.tone_count == 2'd0 && seq_st.light_count == 2'd0 && seq_st.vib_count == 2'd0)
         seq_st.tick_enabled = 1'b0;
   endtask

   task automatic count_battery(input item_type it);
      if (it.charging) begin
         seq_st.low_sample_count = 3'd0;
         seq_st.low_warned = 1'b0;
      end else if (it.battery_level > BATTERY_LOW_PERCENT) begin
         seq_st.low_sample_count = 3'd0;
      end else begin
         if (seq_st.low_sample_count < BATTERY_LOW_SAMPLES)
            seq_st.low_sample_count = seq_st.low_sample_count + 3'd1;
         if (seq_st.low_sample_count >= BATTERY_LOW_SAMPLES && !seq_st.low_warned) begin
            seq_st.low_warned = 1'b1;
            load_pattern(EV_LOW_BATTERY, it.now_ms);
         end
      end
   endtask

   task automatic advance_sequencer(input item_type it);
      result_type r;
      tone_fire = 1'b0;
      tone_hz_out = '0;
      tone_len_out = '0;
      case (it.func)
         FUNC_TICK:    if (seq_st.tick_enabled) advance_channels(it.now_ms, it.speaker_busy);
         FUNC_EVENT:   load_pattern(it.event_code, it.now_ms);
         FUNC_BATTERY: count_battery(it);
         default: ;
      endcase
      r.tone_start = tone_fire;
      r.tone_freq = tone_hz_out;
      r.tone_ms = tone_len_out;
      r.speaker_power = seq_st.speaker_active;
      r.led_pin_level = seq_cfg.capabilities[1] ? seq_st.light_lit ^ seq_cfg.led_invert : 1'b0;
      r.motor_drive = seq_st.vib_active ? VIB_DRIVE : 8'd0;
      r.timer_running = seq_st.tick_enabled;
      predicted_outputs.push_back(r);
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_sequencer(live_item);
            in_flight--;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               live_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= live_item.func;
               req_tdata <= {4'b0, live_item.charging, live_item.battery_level,
                             live_item.speaker_busy, live_item.now_ms, live_item.event_code};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_phase++;
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_style = $urandom_range(0, 3);
               rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_phase % 5) < 2;
            endcase
         end
      end
   end

   // ---------------- monitor ----------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                  results_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (predicted_outputs.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, 32'd0);
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_tdata[0] !== want.tone_start)
               report_mismatch("tone_start", 32'(rsp_tdata[0]), 32'(want.tone_start));
            if (rsp_tdata[12:1] !== want.tone_freq)
               report_mismatch("tone_freq", 32'(rsp_tdata[12:1]), 32'(want.tone_freq));
            if (rsp_tdata[20:13] !== want.tone_ms)
               report_mismatch("tone_ms", 32'(rsp_tdata[20:13]), 32'(want.tone_ms));
            if (rsp_tdata[21] !== want.speaker_power)
               report_mismatch("speaker_power", 32'(rsp_tdata[21]), 32'(want.speaker_power));
            if (rsp_tdata[22] !== want.led_pin_level)
               report_mismatch("led_pin_level", 32'(rsp_tdata[22]), 32'(want.led_pin_level));
            if (rsp_tdata[30:23] !== want.motor_drive)
               report_mismatch("motor_drive", 32'(rsp_tdata[30:23]), 32'(want.motor_drive));
            if (rsp_tdata[31] !== want.timer_running)
               report_mismatch("timer_running", 32'(rsp_tdata[31]), 32'(want.timer_running));
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic push_item(input logic [1:0] f, input logic [2:0] ev, input logic [31:0] now,
                            input logic busy, input logic [6:0] lvl, input logic chg);
      item_type it;
      it.func = f;
      it.event_code = ev;
      it.now_ms = now;
      it.speaker_busy = busy;
      it.battery_level = lvl;
      it.charging = chg;
      pending_items.push_back(it);
      in_flight++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_OUTPUT_MODE:  seq_cfg.output_mode = val[2:0];
         REG_EVENT_ENABLE: seq_cfg.event_enable = val[3:0];
         REG_VOLUME:       seq_cfg.volume = val;
         REG_CAPABILITIES: seq_cfg.capabilities = val[2:0];
         REG_LED_INVERT:   seq_cfg.led_invert = val[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (in_flight != 0 || predicted_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [2:0] mode, input logic [3:0] en,
                                 input logic [7:0] vol, input logic [2:0] caps,
                                 input logic lal);
      settle();
      write_reg(REG_OUTPUT_MODE, {5'd0, mode});
      write_reg(REG_EVENT_ENABLE, {4'd0, en});
      write_reg(REG_VOLUME, vol);
      write_reg(REG_CAPABILITIES, {5'd0, caps});
      write_reg(REG_LED_INVERT, {7'd0, lal});
   endtask

   task automatic step_time();
      wall_ms = wall_ms + $urandom_range(1, 120);
   endtask

   task automatic random_phase(input int n);
      int made, k, r;
      made = 0;
      while (made < n) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            step_time();
            push_item(FUNC_EVENT, 3'($urandom_range(0, 4)), wall_ms, 1'b0, 7'd0, 1'b0);
            made++;
            k = $urandom_range(8, 30);
            repeat (k) begin
               step_time();
               if ($urandom_range(0, 9) == 0)
                  push_item(FUNC_BATTERY, 3'd0, wall_ms, 1'b0, 7'($urandom_range(0, 100)),
                            1'($urandom_range(0, 1)));
               else
                  push_item(FUNC_TICK, 3'd0, wall_ms, $urandom_range(0, 4) == 0, 7'd0, 1'b0);
               made++;
            end
         end else if (r < 70) begin
            k = $urandom_range(5, 8);
            repeat (k) begin
               step_time();
               if ($urandom_range(0, 7) == 0)
                  push_item(FUNC_BATTERY, 3'd0, wall_ms, 1'b0, 7'($urandom_range(0, 100)),
                            1'($urandom_range(0, 1)));
               else
                  push_item(FUNC_BATTERY, 3'd0, wall_ms, 1'b0, 7'($urandom_range(0, 10)),
                            1'b0);
               made++;
            end
         end else if (r < 80) begin
            if ($urandom_range(0, 1) == 0) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else wall_ms = $urandom;
            k = $urandom_range(2, 6);
            repeat (k) begin
               push_item(FUNC_TICK, 3'd0, wall_ms, 1'($urandom_range(0, 1)), 7'd0, 1'b0);
               step_time();
               made++;
            end
         end else begin
            push_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom,
                      1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
            made++;
         end
      end
   endtask

   initial begin
      logic [31:0] t0;
      logic [2:0]  mode;
      logic [3:0]  en;
      logic [7:0]  vol;
      logic [2:0]  caps;
      seq_st = '0;
      seq_cfg.output_mode = MODE_OFF;
      seq_cfg.event_enable = 4'hF;
      seq_cfg.volume = 8'd0;
      seq_cfg.capabilities = 3'd0;
      seq_cfg.led_invert = 1'b1;
      wall_ms = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: mode off, timer stopped, unknown kind
      push_item(FUNC_EVENT, EV_SHUTTER, 32'd0, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, EV_SHUTTER, 32'd100, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_UNUSED, EV_SHUTTER, 32'd200, 1'b1, 7'd0, 1'b0);
      push_item(FUNC_BATTERY, EV_SHUTTER, 32'd300, 1'b0, 7'd127, 1'b1);

      // two-tone pattern across the timestamp wrap, busy hold, low battery run
      apply_settings(MODE_SND_LIGHT, 4'hF, 8'hFF, 3'h7, 1'b0);
      t0 = 32'hFFFF_FFE0;
      push_item(FUNC_EVENT, EV_CONNECTED, t0, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd10, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd60, 1'b1, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd70, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd90, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd150, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd160, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, t0 + 32'd250, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_EVENT, EV_UNASSIGNED, t0 + 32'd260, 1'b0, 7'd0, 1'b0);
      repeat (6) push_item(FUNC_BATTERY, 3'd0, 32'd400, 1'b0, BATTERY_LOW_PERCENT, 1'b0);
      push_item(FUNC_BATTERY, 3'd0, 32'd420, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_BATTERY, 3'd0, 32'd440, 1'b0, 7'd50, 1'b1);

      // countdown in vibrate mode loads no pulse but keeps the motor on
      apply_settings(MODE_VIBRATE, 4'hF, 8'h00, 3'h7, 1'b1);
      push_item(FUNC_EVENT, EV_DISCONNECTED, 32'd1000, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_EVENT, EV_COUNTDOWN, 32'd1010, 1'b0, 7'd0, 1'b0);
      push_item(FUNC_TICK, 3'd0, 32'd1020, 1'b0, 7'd0, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = (p < 8) ? p[2:0] : 3'($urandom_range(1, 4));
         caps = (p % 4 == 3) ? 3'($urandom_range(0, 7)) : 3'h7;
         en = (p == 5) ? 4'h0 : ((p % 3 == 2) ? 4'($urandom_range(0, 15)) : 4'hF);
         vol = (p == 1) ? 8'h00 : ((p == 2) ? 8'hFF : 8'($urandom_range(0, 255)));
         apply_settings(mode, en, vol, caps, p[0]);
         random_phase(PHASE_ITEMS);
      end

      settle();
      if (predicted_outputs.size() != 0)
         report_mismatch("missing results", 32'(predicted_outputs.size()), 32'd0);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/efps_pkg.sv
hw/rtl/efps_engine.sv
hw/rtl/event_feedback_pattern_sequencer_top.sv
dv/testbench.sv
